@@ rtl/core/psf_pkg.sv @@
// Shared types, constants and register codes of the priority source failover unit.
package psf_pkg;

   localparam int MAX_SOURCES_DEF = 4;
   localparam int NUM_TIMEOUTS    = 4;
   localparam int TO_W            = 2;
   localparam int SRC_W           = 3;
   localparam int ACT_W           = 2;
   localparam int TIME_W          = 32;
   localparam int DATA_W          = 32;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT = TIME_W'(3000);

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT3 = 3'd4;

   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_POLL   = 1'b1;

   typedef struct packed {
      logic              func;
      logic [SRC_W-1:0]  source_index;
      logic [DATA_W-1:0] payload;
      logic              is_text;
      logic [TIME_W-1:0] time_ticks;
   } req_type;

   typedef struct packed {
      logic              emitted;
      logic [DATA_W-1:0] out_payload;
      logic              out_is_text;
      logic [TIME_W-1:0] out_stamp;
      logic [ACT_W-1:0]  active_source;
   } rsp_type;

   typedef struct packed {
      logic later;
      logic expired;
   } cmp_type;

endpackage

@@ rtl/core/psf_req_if.sv @@
// Request channel carrying update and poll beats.
interface psf_req_if import psf_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/psf_rsp_if.sv @@
// Response channel carrying poll result beats.
interface psf_rsp_if import psf_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/priority_source_failover_unit.sv @@
// Top level: priority failover selector over up to four timed sources.
//
// Usage:
//   req_chan carries update beats (func 0) and poll beats (func 1). An update
//   stores payload, type tag and stamp for its source when that source is in
//   use and either was never seen or the stamp is later than its last input
//   time; it gives no response. A poll walks the sources in priority order,
//   one source per cycle through one shared subtract/compare unit, and gives
//   exactly one beat on rsp_chan. An update passes through accept and
//   compare/write. A poll passes through accept, a scan of the sources in use
//   that stops at the first unexpired one (skipped when none is in use), and
//   a load of the output register.
//   req_chan.ready is high only while the sequencer is idle, one item at a
//   time. The output register holds a response while rsp_chan is stalled;
//   a following poll finishes its scan and waits for that register to free.
//   csr_we/csr_index/csr_wdata write sources_in_use (0) and the four
//   timeouts (1..4); a zero timeout loads 3000.
//   Reset (synchronous, active high) restores 4 sources, 3000-tick
//   timeouts, active source 0 and marks every source never seen.
module priority_source_failover_unit import psf_pkg::*; #(
   parameter int MAX_SOURCES = MAX_SOURCES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   psf_req_if.sink               req_chan,
   psf_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
   localparam int CNT_W = $clog2(MAX_SOURCES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_UPD  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [SRC_W-1:0]       sources_ff, sources_in;
   logic [TIME_W-1:0]      timeout_ff [NUM_TIMEOUTS];
   logic [TIME_W-1:0]      timeout_in [NUM_TIMEOUTS];
   req_type                item_ff, item_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       active_ff, active_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic [MAX_SOURCES-1:0] known_ff, known_in;
   logic [MAX_SOURCES-1:0] fresh_ff, fresh_in;
   logic [DATA_W-1:0]      payload_ff [MAX_SOURCES];
   logic [DATA_W-1:0]      payload_in [MAX_SOURCES];
   logic                   text_ff [MAX_SOURCES];
   logic                   text_in [MAX_SOURCES];
   logic [TIME_W-1:0]      stamp_ff [MAX_SOURCES];
   logic [TIME_W-1:0]      stamp_in [MAX_SOURCES];
   logic [TIME_W-1:0]      last_ff [MAX_SOURCES];
   logic [TIME_W-1:0]      last_in [MAX_SOURCES];

   logic [CNT_W-1:0]       n_src;
   logic [CNT_W-1:0]       scan_next;
   logic [IDX_W-1:0]       sel;
   logic                   idx_ok;
   logic                   expired;
   logic                   later_ok;
   logic [TIME_W-1:0]      csr_timeout;
   cmp_type                cmp;

   assign n_src = (sources_ff > SRC_W'(MAX_SOURCES)) ? CNT_W'(MAX_SOURCES)
                                                     : CNT_W'(sources_ff);
   assign scan_next = scan_ff + CNT_W'(1);
   assign sel = (state_ff == ST_SCAN) ? scan_ff[IDX_W-1:0]
                                      : item_ff.source_index[IDX_W-1:0];
   assign idx_ok = {1'b0, req_chan.data.source_index} < (SRC_W + 1)'(n_src);
   assign csr_timeout = (csr_wdata == '0) ? DEFAULT_TIMEOUT : csr_wdata;

   psf_time_cmp u_cmp (
      .now     (item_ff.time_ticks),
      .last    (last_ff[sel]),
      .timeout (timeout_ff[TO_W'(sel)]),
      .res     (cmp)
   );

   // never-seen source restarts its clock at this poll, so it cannot expire
   assign expired  = known_ff[sel] & cmp.expired;
   assign later_ok = !known_ff[sel] | cmp.later;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      sources_in   = sources_ff;
      timeout_in   = timeout_ff;
      item_in      = item_ff;
      scan_in      = scan_ff;
      active_in    = active_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      known_in     = known_ff;
      fresh_in     = fresh_ff;
      payload_in   = payload_ff;
      text_in      = text_ff;
      stamp_in     = stamp_ff;
      last_in      = last_ff;

      if (csr_we) begin
         unique case (csr_index) inside
            CSR_SOURCES: begin
               sources_in = csr_wdata[SRC_W-1:0];
            end
            CSR_TIMEOUT0, CSR_TIMEOUT1, CSR_TIMEOUT2, CSR_TIMEOUT3: begin
               timeout_in[TO_W'(csr_index - CSR_TIMEOUT0)] = csr_timeout;
            end
            default: begin
            end
         endcase
      end

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               item_in = req_chan.data;
               if (req_chan.data.func == FUNC_POLL) begin
                  res_in  = '0;
                  scan_in = '0;
                  state_in = (n_src == '0) ? ST_OUT : ST_SCAN;
               end else if (idx_ok) begin
                  state_in = ST_UPD;
               end
            end
         end
         ST_UPD: begin
            if (later_ok) begin
               payload_in[sel] = item_ff.payload;
               text_in[sel]    = item_ff.is_text;
               stamp_in[sel]   = item_ff.time_ticks;
               last_in[sel]    = item_ff.time_ticks;
               known_in[sel]   = 1'b1;
               fresh_in[sel]   = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (!known_ff[sel]) begin
               last_in[sel]  = item_ff.time_ticks;
               known_in[sel] = 1'b1;
            end
            if (!expired) begin
               active_in = sel;
               if (fresh_ff[sel]) begin
                  fresh_in[sel]      = 1'b0;
                  res_in.emitted     = 1'b1;
                  res_in.out_payload = payload_ff[sel];
                  res_in.out_is_text = text_ff[sel];
                  res_in.out_stamp   = stamp_ff[sel];
               end
               state_in = ST_OUT;
            end else begin
               // advance the active index past an expired source, never back
               if (scan_next < n_src && scan_next > CNT_W'(active_ff)) begin
                  active_in = scan_next[IDX_W-1:0];
               end
               scan_in = scan_next;
               if (scan_next == n_src) begin
                  state_in = ST_OUT;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_data_in               = res_ff;
               rsp_data_in.active_source = ACT_W'(active_ff);
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sources_ff   <= SRC_W'(4);
         for (int i = 0; i < NUM_TIMEOUTS; i++) begin
            timeout_ff[i] <= DEFAULT_TIMEOUT;
         end
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         known_ff     <= '0;
         fresh_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         sources_ff   <= sources_in;
         timeout_ff   <= timeout_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         known_ff     <= known_in;
         fresh_ff     <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      scan_ff     <= scan_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      payload_ff  <= payload_in;
      text_ff     <= text_in;
      stamp_ff    <= stamp_in;
      last_ff     <= last_in;
   end

`ifndef SYNTHESIS
   a_quiet_result_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.data.emitted) |->
         (rsp_chan.data.out_payload == '0 && rsp_chan.data.out_stamp == '0 &&
          !rsp_chan.data.out_is_text))
      else $error("quiet poll result carries data");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_ff < n_src))
      else $error("scan index beyond sources in use");

   a_fresh_consumed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && !expired && fresh_ff[sel]) |=>
         (!fresh_ff[$past(sel)] && state_ff == ST_OUT && res_ff.emitted))
      else $error("emitted data not marked used");
`endif

endmodule

@@ rtl/core/psf_time_cmp.sv @@
// Shared time difference unit: later-than and expiry tests on one subtraction.
module psf_time_cmp import psf_pkg::*; (
   input  logic [TIME_W-1:0] now,
   input  logic [TIME_W-1:0] last,
   input  logic [TIME_W-1:0] timeout,
   output cmp_type           res
);

   logic [TIME_W-1:0] diff;

   assign diff = now - last;

   // negative difference is neither later nor expired
   assign res.later   = (diff != '0) && !diff[TIME_W-1];
   assign res.expired = !diff[TIME_W-1] && (diff > timeout);

endmodule

@@ tb/priority_source_failover_unit_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the priority source failover unit: directed rows, then random phases.
module priority_source_failover_unit_tb;
   import psf_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT   = 7;
   localparam int PHASE_BEATS   = 100;
   localparam int REPORT_CAP    = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   psf_req_if req_chan();
   psf_rsp_if rsp_chan();

   priority_source_failover_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // selector state as the bench sees it
   logic [2:0]        cfg_count;
   logic [TIME_W-1:0] cfg_timeout [NUM_TIMEOUTS];
   logic [DATA_W-1:0] sel_payload [MAX_SOURCES_DEF];
   logic              sel_text    [MAX_SOURCES_DEF];
   logic [TIME_W-1:0] sel_stamp   [MAX_SOURCES_DEF];
   logic [TIME_W-1:0] sel_last_in [MAX_SOURCES_DEF];
   logic              sel_known   [MAX_SOURCES_DEF];
   logic              sel_fresh   [MAX_SOURCES_DEF];
   int unsigned       sel_active;

   rsp_type           pending_polls [$];
   dir_row_type       dir_rows [$];
   logic [TIME_W-1:0] tick_now;
   bit                no_idle;
   int                mismatches;
   int                beats_sent;
   int                results_seen;
   int                data_results;
   int                csr_writes;
   int                cycle_count;
   int                stall_left;
   rsp_type           seen_rsp;
   rsp_type           due_rsp;

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch %0s: got %0h, want %0h, cycle %0d", what, got, want, cycle_count);
   endtask

   function automatic int unsigned live_sources();
      return (cfg_count > 3'd4) ? MAX_SOURCES_DEF : int'(cfg_count);
   endfunction

   function automatic bit stamp_later(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] d;
      d = a - b;
      return (d != '0) && !d[TIME_W-1];
   endfunction

   task automatic reset_selector();
      cfg_count = 3'd4;
      for (int i = 0; i < MAX_SOURCES_DEF; i++) begin
         cfg_timeout[i] = DEFAULT_TIMEOUT;
         sel_payload[i] = '0;
         sel_text[i]    = 1'b0;
         sel_stamp[i]   = '0;
         sel_last_in[i] = '0;
         sel_known[i]   = 1'b0;
         sel_fresh[i]   = 1'b0;
      end
      sel_active = 0;
   endtask

   // advance the selector by one beat; a poll yields one result
   task automatic step_selector(input req_type b, output bit gives, output rsp_type res);
      int unsigned       n;
      int unsigned       i;
      logic [TIME_W-1:0] d;
      bit                settled;
      bit                lapsed;
      n = live_sources();
      gives = 1'b0;
      res = '0;
      if (b.func == FUNC_UPDATE) begin
         if (b.source_index < n) begin
            i = b.source_index;
            if (!sel_known[i] || stamp_later(b.time_ticks, sel_last_in[i])) begin
               sel_payload[i] = b.payload;
               sel_text[i]    = b.is_text;
               sel_stamp[i]   = b.time_ticks;
               sel_last_in[i] = b.time_ticks;
               sel_known[i]   = 1'b1;
               sel_fresh[i]   = 1'b1;
            end
         end
      end else begin
         gives = 1'b1;
         settled = 1'b0;
         for (i = 0; i < n && !settled; i++) begin
            // first poll starts the timeout clock of a source never seen
            if (!sel_known[i]) begin
               sel_last_in[i] = b.time_ticks;
               sel_known[i]   = 1'b1;
            end
            d = b.time_ticks - sel_last_in[i];
            lapsed = !d[TIME_W-1] && (d > cfg_timeout[i]);
            if (!lapsed) begin
               settled = 1'b1;
               sel_active = i;
               if (sel_fresh[i]) begin
                  sel_fresh[i]    = 1'b0;
                  res.emitted     = 1'b1;
                  res.out_payload = sel_payload[i];
                  res.out_is_text = sel_text[i];
                  res.out_stamp   = sel_stamp[i];
               end
            end else if (i + 1 < n && i + 1 > sel_active) begin
               sel_active = i + 1;
            end
         end
         res.active_source = ACT_W'(sel_active);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      csr_writes++;
      case (idx)
         CSR_SOURCES:  cfg_count = val[2:0];
         CSR_TIMEOUT0: cfg_timeout[0] = (val == '0) ? DEFAULT_TIMEOUT : val;
         CSR_TIMEOUT1: cfg_timeout[1] = (val == '0) ? DEFAULT_TIMEOUT : val;
         CSR_TIMEOUT2: cfg_timeout[2] = (val == '0) ? DEFAULT_TIMEOUT : val;
         CSR_TIMEOUT3: cfg_timeout[3] = (val == '0) ? DEFAULT_TIMEOUT : val;
         default: ;
      endcase
   endtask

   task automatic set_timeouts(input logic [31:0] t0, input logic [31:0] t1,
                               input logic [31:0] t2, input logic [31:0] t3);
      write_reg(CSR_TIMEOUT0, t0);
      write_reg(CSR_TIMEOUT1, t1);
      write_reg(CSR_TIMEOUT2, t2);
      write_reg(CSR_TIMEOUT3, t3);
   endtask

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_beat(input req_type b, input bit typed, input rsp_type typed_rsp);
      int      gap;
      bit      gives;
      rsp_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= b;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      beats_sent++;
      step_selector(b, gives, res);
      if (gives)
         pending_polls = {pending_polls, (typed ? typed_rsp : res)};
   endtask

   // hold off the sender until every poll result is back, then let the block settle
   task automatic drain_results();
      int waited;
      req_chan.valid <= 1'b0;
      waited = 0;
      while (pending_polls.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_polls.size() != 0) begin
         report_mismatch("results never returned", pending_polls.size(), 0);
         pending_polls.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void add_row(input logic f, input int unsigned src,
                                   input logic [31:0] pay, input logic txt,
                                   input logic [31:0] t, input bit typed = 1'b0,
                                   input logic em = 1'b0, input logic [31:0] opay = '0,
                                   input logic otxt = 1'b0, input logic [31:0] ost = '0,
                                   input int unsigned act = 0);
      dir_row_type row;
      row.beat.func          = f;
      row.beat.source_index  = SRC_W'(src);
      row.beat.payload       = pay;
      row.beat.is_text       = txt;
      row.beat.time_ticks    = t;
      row.typed              = typed;
      row.want.emitted       = em;
      row.want.out_payload   = opay;
      row.want.out_is_text   = otxt;
      row.want.out_stamp     = ost;
      row.want.active_source = ACT_W'(act);
      dir_rows = {dir_rows, row};
   endfunction

   // well-formed traffic around the current time, with some noise
   function automatic req_type next_beat();
      req_type     b;
      int unsigned n;
      int unsigned pick;
      n = live_sources();
      b.payload      = $urandom;
      b.is_text      = 1'($urandom_range(0, 1));
      b.func         = FUNC_POLL;
      b.source_index = SRC_W'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 8) begin
         b.func       = 1'($urandom_range(0, 1));
         b.time_ticks = $urandom;
         return b;
      end
      pick = $urandom_range(0, 19);
      if (pick < 12)
         tick_now += $urandom_range(0, 150);
      else if (pick < 16)
         tick_now += $urandom_range(0, 3500);
      else if (pick < 18)
         tick_now += $urandom_range(2900, 3100);
      else if (pick < 19)
         tick_now -= $urandom_range(0, 400);
      else
         tick_now = $urandom;
      b.time_ticks = tick_now;
      if ($urandom_range(0, 99) < 55) begin
         b.func = FUNC_UPDATE;
         if (n > 0 && $urandom_range(0, 7) != 0)
            b.source_index = SRC_W'($urandom_range(0, n - 1));
         if ($urandom_range(0, 3) == 0)
            b.time_ticks = tick_now - $urandom_range(0, 300);
      end
      return b;
   endfunction

   task automatic setup_phase(input int phase);
      no_idle = (phase == 2 || phase == 5);
      case (phase)
         0: begin
            write_reg(CSR_SOURCES, 4);
            set_timeouts(0, 1, 500, 32'hFFFF_FFFF);
         end
         1: begin
            // shrink the source count while the active index may sit high
            write_reg(CSR_SOURCES, 2);
            write_reg(CSR_TIMEOUT0, 1);
            write_reg(CSR_TIMEOUT1, 1);
         end
         2: write_reg(CSR_SOURCES, 0);
         3: begin
            write_reg(CSR_SOURCES, 7);
            set_timeouts($urandom_range(100, 5000), $urandom_range(100, 5000),
                         $urandom_range(100, 5000), $urandom_range(100, 5000));
            write_reg(CSR_SPARE_LO, $urandom);
         end
         4: begin
            write_reg(CSR_SOURCES, 1);
            write_reg(CSR_TIMEOUT0, 32'hFFFF_FFFF);
            tick_now = 32'hFFFF_F000;
         end
         5: begin
            write_reg(CSR_SOURCES, 3);
            set_timeouts(32'h8000_0000, 32'h7FFF_FFFF, 200, 0);
         end
         default: begin
            write_reg(CSR_SOURCES, $urandom_range(5, 7));
            set_timeouts(0, 0, 0, 0);
            for (int idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++)
               write_reg(CSR_IDX_W'(idx), 32'hFFFF_FFFF);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
         stall_left <= pick_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_rsp = rsp_chan.data;
         results_seen++;
         if (pending_polls.size() == 0) begin
            report_mismatch("result with no poll pending", seen_rsp.out_payload, 0);
         end else begin
            due_rsp = pending_polls.pop_front();
            if (due_rsp.emitted)
               data_results++;
            if (seen_rsp.emitted !== due_rsp.emitted)
               report_mismatch("emitted", seen_rsp.emitted, due_rsp.emitted);
            if (seen_rsp.out_payload !== due_rsp.out_payload)
               report_mismatch("out_payload", seen_rsp.out_payload, due_rsp.out_payload);
            if (seen_rsp.out_is_text !== due_rsp.out_is_text)
               report_mismatch("out_is_text", seen_rsp.out_is_text, due_rsp.out_is_text);
            if (seen_rsp.out_stamp !== due_rsp.out_stamp)
               report_mismatch("out_stamp", seen_rsp.out_stamp, due_rsp.out_stamp);
            if (seen_rsp.active_source !== due_rsp.active_source)
               report_mismatch("active_source", seen_rsp.active_source,
                               due_rsp.active_source);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_polls.size());
         $display("priority_source_failover_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      req_chan.valid <= 1'b0;
      req_chan.data  <= '0;
      csr_we         <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      reset          <= 1'b1;
      reset_selector();
      no_idle  = 1'b0;
      tick_now = '0;

      // reset state, extremes, stale and wrapped stamps, failover down and back up
      add_row(FUNC_POLL,   0, 0,            0, 0,            1, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 0, 32'hFFFF_FFFF, 1, 100);
      add_row(FUNC_POLL,   5, 0,            0, 100,          1, 1, 32'hFFFF_FFFF, 1, 100, 0);
      add_row(FUNC_POLL,   0, 0,            0, 100,          1, 0, 0, 0, 0, 0);
      add_row(FUNC_UPDATE, 0, 0,            0, 50);
      add_row(FUNC_UPDATE, 7, 32'hDEAD_BEEF, 1, 200);
      add_row(FUNC_UPDATE, 3, 0,            0, 32'hFFFF_FFFF);
      add_row(FUNC_POLL,   0, 0,            0, 3100,         1, 0, 0, 0, 0, 0);
      add_row(FUNC_POLL,   0, 0,            0, 3101,         1, 0, 0, 0, 0, 1);
      add_row(FUNC_UPDATE, 2, 32'h1234_5678, 0, 3200);
      add_row(FUNC_POLL,   0, 0,            0, 3200,         1, 0, 0, 0, 0, 1);
      add_row(FUNC_UPDATE, 1, 32'hA5A5_A5A5, 1, 3300);
      add_row(FUNC_POLL,   0, 0,            0, 3300);
      add_row(FUNC_POLL,   0, 0,            0, 10);
      add_row(FUNC_UPDATE, 3, 32'h55AA_55AA, 1, 7000);
      add_row(FUNC_POLL,   2, 0,            0, 7000);
      add_row(FUNC_UPDATE, 0, 0,            0, 7001);
      add_row(FUNC_POLL,   0, 0,            0, 7001);
      add_row(FUNC_UPDATE, 4, 32'hFFFF_FFFF, 1, 7100);
      add_row(FUNC_POLL,   7, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[k])
         send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         setup_phase(phase);
         for (int k = 0; k < PHASE_BEATS; k++) begin
            if ($urandom_range(0, 79) == 0)
               drain_results();
            send_beat(next_beat(), 1'b0, '0);
         end
         drain_results();
      end

      $display("%0d beats sent, %0d poll results compared, %0d of them carrying data",
               beats_sent, results_seen, data_results);
      $display("%0d register writes over %0d settings, source counts 0 to 7, extreme timeouts",
               csr_writes, PHASE_COUNT + 1);
      if (mismatches == 0) begin
         $display("priority_source_failover_unit_tb: done, clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("priority_source_failover_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
